### rtl/core/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Beat types, operation and status codes, pipeline stage types and saturation.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int MAG_BITS  = 2 * WORD_BITS + 1;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]                  operation;
      logic signed [WORD_BITS-1:0] a_re;
      logic signed [WORD_BITS-1:0] a_im;
      logic signed [WORD_BITS-1:0] b_re;
      logic signed [WORD_BITS-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_re;
      logic signed [WORD_BITS-1:0] res_im;
      logic [1:0]                  status;
   } rsp_type;

   // products and part sums
   typedef struct packed {
      logic [1:0]                  op;
      logic                        dz;
      logic signed [PROD_BITS-1:0] p_rr;
      logic signed [PROD_BITS-1:0] p_ii;
      logic signed [PROD_BITS-1:0] p_ri;
      logic signed [PROD_BITS-1:0] p_ir;
      logic signed [PROD_BITS-1:0] sq_r;
      logic signed [PROD_BITS-1:0] sq_i;
      logic signed [WORD_BITS:0]   sum_re;
      logic signed [WORD_BITS:0]   sum_im;
   } s1_type;

   // combined parts and divisor
   typedef struct packed {
      logic [1:0]                 op;
      logic                       dz;
      logic signed [MAG_BITS-1:0] re_s;
      logic signed [MAG_BITS-1:0] im_s;
      logic [PROD_BITS-1:0]       den;
   } s2_type;

   // divider stage
   typedef struct packed {
      logic                 is_div;
      logic                 dz;
      logic                 neg_re;
      logic                 neg_im;
      logic                 ovf_re;
      logic                 ovf_im;
      logic [PROD_BITS-1:0] den;
      logic [MAG_BITS-1:0]  rem_re;
      logic [MAG_BITS-1:0]  rem_im;
      logic [WORD_BITS-1:0] low_re;
      logic [WORD_BITS-1:0] low_im;
      logic [WORD_BITS-1:0] q_re;
      logic [WORD_BITS-1:0] q_im;
      rsp_type              res;
   } dv_type;

   typedef struct packed {
      logic                 ovf;
      logic [WORD_BITS-1:0] val;
   } sat_type;

   function automatic sat_type sat_word(input logic neg, input logic [MAG_BITS-1:0] mag);
      sat_type             r;
      logic [MAG_BITS-1:0] top;
      top = MAG_BITS'(1) << (WORD_BITS - 1);
      r.ovf = 1'b0;
      if (!neg) begin
         if (mag > top - MAG_BITS'(1)) begin
            r.ovf = 1'b1;
            r.val = WORD_BITS'(top - MAG_BITS'(1));
         end else begin
            r.val = mag[WORD_BITS-1:0];
         end
      end else begin
         if (mag > top) begin
            r.ovf = 1'b1;
            r.val = WORD_BITS'(top);
         end else begin
            r.val = ~mag[WORD_BITS-1:0] + WORD_BITS'(1);
         end
      end
      return r;
   endfunction

endpackage

### rtl/core/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of complex Q16.16 values, saturating.
//
//  channel  ports                        direction
//  req      req_valid/req_stall/req_data  in   (operation, a, b)
//  rsp      rsp_valid/rsp_stall/rsp_data  out  (res, status)
//
// One beat per cycle unless the result side stalls; every operation takes
// the same path through the restoring divider, one quotient bit per stage.
// Each stage holds its valid bit and moves on whenever the next one is free,
// so bubbles close up and input is taken while a result waits.
// Synchronous reset clears all valid bits.
// ----------------------------------------------------------------------------
module complex_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam int NUM_BITS = MAG_BITS + FRAC_BITS;
   localparam int TOP_BITS = NUM_BITS - WORD_BITS;

   logic    s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   rsp_type rsp_ff, rsp_in;
   logic    dv_valid_ff [WORD_BITS+1];
   dv_type  dv_ff       [WORD_BITS+1];
   dv_type  dv_in       [WORD_BITS+1];
   logic    take_dv     [WORD_BITS+1];
   logic    take_s1, take_s2, take_out;

   // advance chain
   assign take_out = !rsp_valid_ff || !rsp_stall;
   assign take_dv[WORD_BITS] = !dv_valid_ff[WORD_BITS] || take_out;
   genvar g;
   generate
      for (g = 0; g < WORD_BITS; g++) begin : g_take
         assign take_dv[g] = !dv_valid_ff[g] || take_dv[g+1];
      end
   endgenerate
   assign take_s2   = !s2_valid_ff || take_dv[0];
   assign take_s1   = !s1_valid_ff || take_s2;
   assign req_stall = !take_s1;

   // stage 1: products, part sums and zero-divisor flag
   always_comb begin
      s1_in.op     = req_data.operation;
      s1_in.dz     = (req_data.b_re == '0) && (req_data.b_im == '0);
      s1_in.p_rr   = PROD_BITS'(req_data.a_re) * PROD_BITS'(req_data.b_re);
      s1_in.p_ii   = PROD_BITS'(req_data.a_im) * PROD_BITS'(req_data.b_im);
      s1_in.p_ri   = PROD_BITS'(req_data.a_re) * PROD_BITS'(req_data.b_im);
      s1_in.p_ir   = PROD_BITS'(req_data.a_im) * PROD_BITS'(req_data.b_re);
      s1_in.sq_r   = PROD_BITS'(req_data.b_re) * PROD_BITS'(req_data.b_re);
      s1_in.sq_i   = PROD_BITS'(req_data.b_im) * PROD_BITS'(req_data.b_im);
      if (req_data.operation == OP_SUB) begin
         s1_in.sum_re = (WORD_BITS+1)'(req_data.a_re) - (WORD_BITS+1)'(req_data.b_re);
         s1_in.sum_im = (WORD_BITS+1)'(req_data.a_im) - (WORD_BITS+1)'(req_data.b_im);
      end else begin
         s1_in.sum_re = (WORD_BITS+1)'(req_data.a_re) + (WORD_BITS+1)'(req_data.b_re);
         s1_in.sum_im = (WORD_BITS+1)'(req_data.a_im) + (WORD_BITS+1)'(req_data.b_im);
      end
   end

   // stage 2: combine
   always_comb begin
      s2_in.op  = s1_ff.op;
      s2_in.dz  = s1_ff.dz;
      s2_in.den = PROD_BITS'(s1_ff.sq_r) + PROD_BITS'(s1_ff.sq_i);
      case (s1_ff.op)
         OP_MUL: begin
            s2_in.re_s = MAG_BITS'(s1_ff.p_rr) - MAG_BITS'(s1_ff.p_ii);
            s2_in.im_s = MAG_BITS'(s1_ff.p_ri) + MAG_BITS'(s1_ff.p_ir);
         end
         OP_DIV: begin
            s2_in.re_s = MAG_BITS'(s1_ff.p_rr) + MAG_BITS'(s1_ff.p_ii);
            s2_in.im_s = MAG_BITS'(s1_ff.p_ir) - MAG_BITS'(s1_ff.p_ri);
         end
         default: begin
            s2_in.re_s = MAG_BITS'(s1_ff.sum_re);
            s2_in.im_s = MAG_BITS'(s1_ff.sum_im);
         end
      endcase
   end

   // stage 3: magnitudes, scale and saturate, divider setup
   logic                neg_re, neg_im;
   logic [MAG_BITS-1:0] mag_re, mag_im, scl_re, scl_im;
   logic [NUM_BITS-1:0] num_re, num_im, den_ext;
   logic [TOP_BITS-1:0] top_re, top_im;
   sat_type             sr3, si3;
   always_comb begin
      neg_re  = s2_ff.re_s[MAG_BITS-1];
      neg_im  = s2_ff.im_s[MAG_BITS-1];
      mag_re  = neg_re ? MAG_BITS'(-s2_ff.re_s) : MAG_BITS'(s2_ff.re_s);
      mag_im  = neg_im ? MAG_BITS'(-s2_ff.im_s) : MAG_BITS'(s2_ff.im_s);
      scl_re  = (s2_ff.op == OP_MUL) ? (mag_re >> FRAC_BITS) : mag_re;
      scl_im  = (s2_ff.op == OP_MUL) ? (mag_im >> FRAC_BITS) : mag_im;
      sr3     = sat_word(neg_re, scl_re);
      si3     = sat_word(neg_im, scl_im);
      num_re  = NUM_BITS'(mag_re) << FRAC_BITS;
      num_im  = NUM_BITS'(mag_im) << FRAC_BITS;
      top_re  = num_re[NUM_BITS-1:WORD_BITS];
      top_im  = num_im[NUM_BITS-1:WORD_BITS];
      den_ext = NUM_BITS'(s2_ff.den);

      dv_in[0].is_div = (s2_ff.op == OP_DIV);
      dv_in[0].dz     = s2_ff.dz;
      dv_in[0].neg_re = neg_re;
      dv_in[0].neg_im = neg_im;
      dv_in[0].ovf_re = NUM_BITS'(top_re) >= den_ext;
      dv_in[0].ovf_im = NUM_BITS'(top_im) >= den_ext;
      dv_in[0].den    = s2_ff.den;
      dv_in[0].rem_re = MAG_BITS'(top_re);
      dv_in[0].rem_im = MAG_BITS'(top_im);
      dv_in[0].low_re = num_re[WORD_BITS-1:0];
      dv_in[0].low_im = num_im[WORD_BITS-1:0];
      dv_in[0].q_re   = '0;
      dv_in[0].q_im   = '0;
      dv_in[0].res.res_re = sr3.val;
      dv_in[0].res.res_im = si3.val;
      dv_in[0].res.status = (sr3.ovf || si3.ovf) ? ST_OVERFLOW : ST_OK;
   end

   // divider stages: one quotient bit each
   generate
      for (g = 0; g < WORD_BITS; g++) begin : g_div
         logic [MAG_BITS-1:0] tr_re, tr_im, dm;
         logic                ge_re, ge_im;
         always_comb begin
            dm    = MAG_BITS'(dv_ff[g].den);
            tr_re = {dv_ff[g].rem_re[MAG_BITS-2:0], dv_ff[g].low_re[WORD_BITS-1]};
            tr_im = {dv_ff[g].rem_im[MAG_BITS-2:0], dv_ff[g].low_im[WORD_BITS-1]};
            ge_re = tr_re >= dm;
            ge_im = tr_im >= dm;
            dv_in[g+1]        = dv_ff[g];
            dv_in[g+1].rem_re = ge_re ? tr_re - dm : tr_re;
            dv_in[g+1].rem_im = ge_im ? tr_im - dm : tr_im;
            dv_in[g+1].low_re = dv_ff[g].low_re << 1;
            dv_in[g+1].low_im = dv_ff[g].low_im << 1;
            dv_in[g+1].q_re   = {dv_ff[g].q_re[WORD_BITS-2:0], ge_re};
            dv_in[g+1].q_im   = {dv_ff[g].q_im[WORD_BITS-2:0], ge_im};
         end
      end
   endgenerate

   // output stage
   sat_type sro, sio;
   always_comb begin
      sro = sat_word(dv_ff[WORD_BITS].neg_re,
                     dv_ff[WORD_BITS].ovf_re ? '1 : MAG_BITS'(dv_ff[WORD_BITS].q_re));
      sio = sat_word(dv_ff[WORD_BITS].neg_im,
                     dv_ff[WORD_BITS].ovf_im ? '1 : MAG_BITS'(dv_ff[WORD_BITS].q_im));
      if (!dv_ff[WORD_BITS].is_div) begin
         rsp_in = dv_ff[WORD_BITS].res;
      end else if (dv_ff[WORD_BITS].dz) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = ST_DIV_ZERO;
      end else begin
         rsp_in.res_re = sro.val;
         rsp_in.res_im = sio.val;
         rsp_in.status = (sro.ovf || sio.ovf) ? ST_OVERFLOW : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_s1)  s1_valid_ff  <= req_valid;
         if (take_s2)  s2_valid_ff  <= s1_valid_ff;
         if (take_out) rsp_valid_ff <= dv_valid_ff[WORD_BITS];
      end
      if (take_s1 && req_valid)                 s1_ff  <= s1_in;
      if (take_s2 && s1_valid_ff)               s2_ff  <= s2_in;
      if (take_out && dv_valid_ff[WORD_BITS])   rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (take_dv[0]) begin
         dv_valid_ff[0] <= s2_valid_ff;
      end
      if (take_dv[0] && s2_valid_ff) dv_ff[0] <= dv_in[0];
   end

   generate
      for (g = 0; g < WORD_BITS; g++) begin : g_dvreg
         always_ff @(posedge clock) begin
            if (reset) begin
               dv_valid_ff[g+1] <= 1'b0;
            end else if (take_dv[g+1]) begin
               dv_valid_ff[g+1] <= dv_valid_ff[g];
            end
            if (take_dv[g+1] && dv_valid_ff[g]) dv_ff[g+1] <= dv_in[g+1];
         end
      end
   endgenerate

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.status == ST_OK || rsp_ff.status == ST_DIV_ZERO
                        || rsp_ff.status == ST_OVERFLOW))
      else $error("reserved status code on output");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_DIV_ZERO)
      |-> (rsp_ff.res_re == '0 && rsp_ff.res_im == '0))
      else $error("divide by zero result not cleared");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (dv_valid_ff[WORD_BITS] && dv_ff[WORD_BITS].is_div && !dv_ff[WORD_BITS].dz
       && !dv_ff[WORD_BITS].ovf_re)
      |-> (dv_ff[WORD_BITS].rem_re < MAG_BITS'(dv_ff[WORD_BITS].den)))
      else $error("divider remainder out of range");

   a_room_taken: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> !req_stall)
      else $error("input stalled with empty first stage");
`endif

endmodule

### tb/tb_complex_arith_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Sends add, subtract, multiply and divide beats under random idling on both
// channels and a long result hold-off. Each result beat is compared whole
// against an in-order queue filled by an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;
   import cau_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = WORD_BITS + 40;
   localparam int RX_HOLD_CYCLES = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_results[$];
   int      tx_idle_pct;
   int      rx_idle_pct;
   int      rx_hold_req = 0;
   int      rx_hold_ack = 0;
   int      rx_hold_cycles = 0;
   int      mismatches = 0;
   int      cycles = 0;

   complex_arith_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic signed [127:0] widen(input logic [31:0] v);
      widen = {{96{v[31]}}, v};
   endfunction

   function automatic logic [127:0] magnitude(input logic signed [127:0] v);
      magnitude = v[127] ? -v : v;
   endfunction

   // clamp to the word; flag when clamped
   function automatic logic [31:0] clamp_part(input logic signed [127:0] v,
                                              inout logic ovf);
      if (v > widen(32'h7fff_ffff)) begin
         ovf = 1'b1;
         clamp_part = 32'h7fff_ffff;
      end else if (v < widen(32'h8000_0000)) begin
         ovf = 1'b1;
         clamp_part = 32'h8000_0000;
      end else begin
         clamp_part = v[31:0];
      end
   endfunction

   function automatic logic signed [127:0] scale_down(input logic signed [127:0] v);
      logic [127:0] m;
      m = magnitude(v) >> 16;
      scale_down = v[127] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [127:0] div_part(input logic signed [127:0] n,
                                                    input logic [127:0] den);
      logic [127:0] q;
      q = (magnitude(n) << 16) / den;
      div_part = n[127] ? -$signed(q) : $signed(q);
   endfunction

   function automatic rsp_type complex_result(input req_type r);
      rsp_type                o;
      logic signed [127:0]    ar, ai, br, bi, re, im;
      logic [127:0]           den;
      logic                   ovf;
      ar  = widen(r.a_re);
      ai  = widen(r.a_im);
      br  = widen(r.b_re);
      bi  = widen(r.b_im);
      ovf = 1'b0;
      re  = '0;
      im  = '0;
      den = '0;
      case (r.operation)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = scale_down(ar * br - ai * bi);
            im = scale_down(ar * bi + ai * br);
         end
         default: begin
            den = br * br + bi * bi;
            if (den != 0) begin
               re = div_part(ar * br + ai * bi, den);
               im = div_part(ai * br - ar * bi, den);
            end
         end
      endcase
      if (r.operation == OP_DIV && den == 0) begin
         o.res_re = '0;
         o.res_im = '0;
         o.status = ST_DIV_ZERO;
      end else begin
         o.res_re = clamp_part(re, ovf);
         o.res_im = clamp_part(im, ovf);
         o.status = ovf ? ST_OVERFLOW : ST_OK;
      end
      return o;
   endfunction

   function automatic logic [31:0] random_part();
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: v = 32'h7fff_ffff;
               1: v = 32'h8000_0000;
               2: v = 32'h0000_0000;
               3: v = 32'h0001_0000;
               default: v = 32'hffff_ffff;
            endcase
         end
         2: v = $urandom_range(0, 262143);
         3: v = $urandom >> $urandom_range(0, 31);
         4: v = $urandom >> $urandom_range(8, 24);
         default: v = $urandom_range(0, 3);
      endcase
      if ($urandom_range(0, 1))
         v = -v;
      return v;
   endfunction

   function automatic req_type random_beat();
      req_type r;
      r.operation = 2'($urandom_range(0, 3));
      r.a_re = random_part();
      r.a_im = random_part();
      r.b_re = random_part();
      r.b_im = random_part();
      if (r.operation == OP_DIV && $urandom_range(0, 19) == 0) begin
         r.b_re = '0;
         r.b_im = '0;
      end
      return r;
   endfunction

   task automatic send_beat(input req_type r);
      logic taken;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
   endtask

   task automatic send_parts(input logic [1:0] op, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
      req_type r;
      r.operation = op;
      r.a_re = ar;
      r.a_im = ai;
      r.b_re = br;
      r.b_im = bi;
      send_beat(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_parts(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000);
      send_parts(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
      send_parts(OP_ADD, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_parts(OP_SUB, 32'h0005_0000, 32'h0001_8000, 32'h0002_0000, 32'h0003_0000);
      send_parts(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
      send_parts(OP_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
      send_parts(OP_MUL, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000);
      send_parts(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_parts(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_parts(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0003);
      send_parts(OP_MUL, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_parts(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
      send_parts(OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
      send_parts(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000);
      send_parts(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
      send_parts(OP_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'h0000_0000);
      send_parts(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_parts(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff);
      send_parts(OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001);
      send_parts(OP_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      wait_idle();
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            // stretch with no idling
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if ($urandom_range(0, 9) == 0) begin
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
         end
         send_beat(random_beat());
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold_req++;
      for (int i = 0; i < 200; i++)
         send_beat(random_beat());
      wait_idle();
   endtask

   // receiver side: random stall plus an optional long hold-off
   always @(posedge clock) begin
      if (rx_hold_req != rx_hold_ack) begin
         rx_hold_ack    <= rx_hold_req;
         rx_hold_cycles <= RX_HOLD_CYCLES - 1;
         rsp_stall      <= 1'b1;
      end else if (rx_hold_cycles > 0) begin
         rx_hold_cycles <= rx_hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // sample between edges; a beat seen here is taken at the next rising edge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_results.push_back(complex_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat re=%h im=%h status=%0d",
                           rsp_data.res_re, rsp_data.res_im, rsp_data.status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp re=%h im=%h st=%0d got re=%h im=%h st=%0d",
                              want.res_re, want.res_im, want.status,
                              rsp_data.res_re, rsp_data.res_im, rsp_data.status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(31, 63, 600);
      test_random(63, 31, 600);
      test_random(0, 0, 500);
      test_backpressure();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
